/* hw/rtl/iolb_pkg.sv */
`timescale 1ns / 1ps
// shared constants, types and index helper for the ordered list buffer
package iolb_pkg;

    localparam int DEPTH  = 16;
    localparam int DATA_W = 32;
    localparam int FUNC_W = 2;
    localparam int POS_W  = 5;
    localparam int OCNT_W = 5;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CMP_W  = (POS_W > CNT_W) ? POS_W : CNT_W;

    localparam logic [FUNC_W-1:0] FUNC_PUSH   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_POP    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd3;

    typedef struct packed {
        logic signed [DATA_W-1:0] popped_value;
        logic signed [DATA_W-1:0] front_value;
        logic [OCNT_W-1:0]        entry_count;
        logic                     is_empty;
        logic                     is_full;
        logic                     dropped;
    } t_result;

    typedef struct packed {
        logic              wr_en;
        logic [IDX_W-1:0]  wr_addr;
        logic [DATA_W-1:0] wr_data;
        logic              rd_en;
        logic [IDX_W-1:0]  rd_addr;
    } t_mem_req;

    // circular address: base plus offset, offset never above DEPTH
    function automatic logic [IDX_W-1:0] idx_add(input logic [IDX_W-1:0] base,
                                                 input logic [CNT_W-1:0] off);
        logic [CNT_W:0] sum;
        sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
        if (sum >= (CNT_W+1)'(DEPTH)) begin
            sum = sum - (CNT_W+1)'(DEPTH);
        end
        return IDX_W'(sum);
    endfunction

endpackage

/* hw/rtl/iolb_if.sv */
`timescale 1ns / 1ps
// command and response channel interfaces
interface iolb_cmd_if import iolb_pkg::*; ;
    logic                     valid;
    logic                     ready;
    logic [FUNC_W-1:0]        func;
    logic signed [DATA_W-1:0] value;
    logic [POS_W-1:0]         position;

    modport source (output valid, func, value, position, input ready);
    modport sink (input valid, func, value, position, output ready);
endinterface

interface iolb_rsp_if import iolb_pkg::*; ;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] popped_value;
    logic signed [DATA_W-1:0] front_value;
    logic [OCNT_W-1:0]        entry_count;
    logic                     is_empty;
    logic                     is_full;
    logic                     dropped;

    modport source (output valid, popped_value, front_value, entry_count, is_empty,
                    is_full, dropped, input ready);
    modport sink (input valid, popped_value, front_value, entry_count, is_empty,
                  is_full, dropped, output ready);
endinterface

/* hw/rtl/insertable_ordered_list_buffer.sv */
`timescale 1ns / 1ps
// top level of the ordered list buffer with positional insert
//
//  channel  dir  handshake      payload
//  i_cmd    in   valid/ready    func, value, position
//  o_rsp    out  valid/ready    popped_value, front_value, entry_count,
//                               is_empty, is_full, dropped
//
// push, clear, refused ops and appending inserts go straight to the done state,
// a pop with entries left behind first does one ram read for the new front,
// an insert at index p with n entries moves n-p entries, with one read and one
// write per moved entry through the single ram port pair, then writes the value.
// reset is synchronous and empties the buffer; ram contents are not cleared.
// a held response stalls the next command only in its done state.
module insertable_ordered_list_buffer import iolb_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    iolb_cmd_if.sink   i_cmd,
    iolb_rsp_if.source o_rsp
);

    t_mem_req          mem;
    logic [DATA_W-1:0] rd_data;
    logic              res_valid;
    t_result           res;
    logic              res_free;
    logic              r_ov;
    t_result           r_rsp;

    iolb_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (i_cmd),
        .o_mem       (mem),
        .i_rd_data   (rd_data),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_free  (res_free)
    );

    iolb_ram #(
        .DW    (DATA_W),
        .AW    (IDX_W),
        .WORDS (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (mem.wr_en),
        .i_wr_addr (mem.wr_addr),
        .i_wr_data (mem.wr_data),
        .i_rd_en   (mem.rd_en),
        .i_rd_addr (mem.rd_addr),
        .o_rd_data (rd_data)
    );

    assign res_free = !r_ov || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (res_free) begin
            r_ov <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_free && res_valid) begin
            r_rsp <= res;
        end
    end

    assign o_rsp.valid        = r_ov;
    assign o_rsp.popped_value = r_rsp.popped_value;
    assign o_rsp.front_value  = r_rsp.front_value;
    assign o_rsp.entry_count  = r_rsp.entry_count;
    assign o_rsp.is_empty     = r_rsp.is_empty;
    assign o_rsp.is_full      = r_rsp.is_full;
    assign o_rsp.dropped      = r_rsp.dropped;

endmodule

/* hw/rtl/iolb_ram.sv */
`timescale 1ns / 1ps
// generic single-write single-read synchronous ram, registered read data
module iolb_ram #(
    parameter int DW    = 32,
    parameter int AW    = 4,
    parameter int WORDS = 16
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [DW-1:0] o_rd_data
);

    logic [DW-1:0] r_mem [WORDS];
    logic [DW-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* hw/rtl/iolb_seq.sv */
`timescale 1ns / 1ps
// operation sequencer: head, count, front cache and the insert shift pass
module iolb_seq import iolb_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    iolb_cmd_if.sink          i_cmd,
    output t_mem_req          o_mem,
    input  logic [DATA_W-1:0] i_rd_data,
    output logic              o_res_valid,
    output t_result           o_res,
    input  logic              i_res_free
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_WR   = 3'd2;
    localparam logic [2:0] S_INS  = 3'd3;
    localparam logic [2:0] S_FRD  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]        r_state, n_state;
    logic [IDX_W-1:0]  r_head, n_head;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [DATA_W-1:0] r_front, n_front;
    logic [DATA_W-1:0] r_popped, n_popped;
    logic              r_dropped, n_dropped;
    logic [CNT_W-1:0]  r_k, n_k;
    logic [CNT_W-1:0]  r_p, n_p;
    logic [DATA_W-1:0] r_val, n_val;

    logic              full;
    logic [CNT_W-1:0]  ins_p;
    t_mem_req          mem;

    assign full  = (r_count == CNT_W'(DEPTH));
    assign ins_p = (CMP_W'(i_cmd.position) >= CMP_W'(r_count)) ? r_count
                 : CNT_W'(i_cmd.position);

    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_count   = r_count;
        n_front   = r_front;
        n_popped  = r_popped;
        n_dropped = r_dropped;
        n_k       = r_k;
        n_p       = r_p;
        n_val     = r_val;
        mem.wr_en   = 1'b0;
        mem.wr_addr = '0;
        mem.wr_data = r_val;
        mem.rd_en   = 1'b0;
        mem.rd_addr = '0;
        o_res_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_cmd.valid) begin
                    n_popped  = '0;
                    n_dropped = 1'b0;
                    n_val     = i_cmd.value;
                    n_state   = S_DONE;
                    case (i_cmd.func)
                        FUNC_PUSH: begin
                            if (full) begin
                                n_dropped = 1'b1;
                            end else begin
                                mem.wr_en   = 1'b1;
                                mem.wr_addr = idx_add(r_head, r_count);
                                mem.wr_data = i_cmd.value;
                                if (r_count == '0) begin
                                    n_front = i_cmd.value;
                                end
                                n_count = r_count + CNT_W'(1);
                            end
                        end
                        FUNC_POP: begin
                            if (r_count != '0) begin
                                n_popped = r_front;
                                n_head   = idx_add(r_head, CNT_W'(1));
                                n_count  = r_count - CNT_W'(1);
                                if (r_count > CNT_W'(1)) begin
                                    mem.rd_en   = 1'b1;
                                    mem.rd_addr = idx_add(r_head, CNT_W'(1));
                                    n_state     = S_FRD;
                                end
                            end
                        end
                        FUNC_INSERT: begin
                            if (full) begin
                                n_dropped = 1'b1;
                            end else if (ins_p == r_count) begin
                                mem.wr_en   = 1'b1;
                                mem.wr_addr = idx_add(r_head, r_count);
                                mem.wr_data = i_cmd.value;
                                if (r_count == '0) begin
                                    n_front = i_cmd.value;
                                end
                                n_count = r_count + CNT_W'(1);
                            end else begin
                                n_p     = ins_p;
                                n_k     = r_count - CNT_W'(1);
                                n_state = S_RD;
                            end
                        end
                        FUNC_CLEAR: begin
                            n_count = '0;
                            n_head  = '0;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_RD: begin
                mem.rd_en   = 1'b1;
                mem.rd_addr = idx_add(r_head, r_k);
                n_state     = S_WR;
            end
            S_WR: begin
                mem.wr_en   = 1'b1;
                mem.wr_addr = idx_add(r_head, r_k + CNT_W'(1));
                mem.wr_data = i_rd_data;
                if (r_k == r_p) begin
                    n_state = S_INS;
                end else begin
                    n_k     = r_k - CNT_W'(1);
                    n_state = S_RD;
                end
            end
            S_INS: begin
                mem.wr_en   = 1'b1;
                mem.wr_addr = idx_add(r_head, r_p);
                mem.wr_data = r_val;
                if (r_p == '0) begin
                    n_front = r_val;
                end
                n_count = r_count + CNT_W'(1);
                n_state = S_DONE;
            end
            S_FRD: begin
                n_front = i_rd_data;
                n_state = S_DONE;
            end
            S_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_front   <= n_front;
        r_popped  <= n_popped;
        r_dropped <= n_dropped;
        r_k       <= n_k;
        r_p       <= n_p;
        r_val     <= n_val;
    end

    assign i_cmd.ready = (r_state == S_IDLE);
    assign o_mem       = mem;

    always_comb begin
        o_res.popped_value = r_popped;
        o_res.front_value  = (r_count != '0) ? r_front : '0;
        o_res.entry_count  = OCNT_W'(r_count);
        o_res.is_empty     = (r_count == '0);
        o_res.is_full      = full;
        o_res.dropped      = r_dropped;
    end

endmodule
